### rtl/vpt_pkg.sv
// Package for the variant path tokenizer: character codes, role and error codes,
// item and result types, and the default index width.
// Used by every module of the block.
`default_nettype none

package vpt_pkg;

  localparam int INDEX_BITS_DEF = 31;
  localparam int CFG_W          = 31;
  localparam int CHAR_W         = 8;
  localparam int STEP_W         = 8;
  localparam int IDX_OUT_W      = 31;

  localparam logic [CHAR_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_OPEN   = 8'h5B;
  localparam logic [CHAR_W-1:0] CH_CLOSE  = 8'h5D;
  localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;

  localparam logic [1:0] ROLE_NONE  = 2'd0;
  localparam logic [1:0] ROLE_NAME  = 2'd1;
  localparam logic [1:0] ROLE_INDEX = 2'd2;

  localparam logic [2:0] ERR_OK         = 3'd0;
  localparam logic [2:0] ERR_UNEXPECTED = 3'd1;
  localparam logic [2:0] ERR_TRAIL_DOT  = 3'd2;
  localparam logic [2:0] ERR_NO_DIGITS  = 3'd3;
  localparam logic [2:0] ERR_RANGE      = 3'd4;
  localparam logic [2:0] ERR_NO_CLOSE   = 3'd5;
  localparam logic [2:0] ERR_EMPTY      = 3'd6;

  typedef struct packed {
    logic              req_type;
    logic [CHAR_W-1:0] char_in;
  } item_t;

  typedef struct packed {
    logic [2:0]           error_code;
    logic [IDX_OUT_W-1:0] index_value;
    logic [STEP_W-1:0]    step_count;
    logic                 step_start;
    logic [1:0]           char_role;
    logic [CHAR_W-1:0]    char_out;
    logic                 path_done;
  } result_t;

  // Accumulator width: never wider than the index limit register.
  function automatic int acc_width(input int index_bits);
    acc_width = (index_bits < CFG_W) ? index_bits : CFG_W;
  endfunction

endpackage

`default_nettype wire

### rtl/variant_path_tokenizer.sv
// Top level of the variant path tokenizer: input register, limit register
// and parse stage. Depends on vpt_pkg, vpt_cfg and vpt_parse.
//
// Usage:
//   in_*  : one path byte per transaction (in_tdata), in_tlast high marks the
//           end-of-path transaction, whose data byte is ignored.
//   out_* : one result per input transaction, in order; out_tlast marks the
//           result of the end-of-path transaction, which also carries the
//           final error code. Per-path state is cleared after it.
//   cfg_* : writes the largest accepted index value; cfg_ready is always high.
//           Write only while no transaction is in flight.
// Each transaction passes from the input register into the result register,
// which offers its result on out_*.
// Throughput: one transaction per cycle while results are taken; the parse
// state is updated as each item moves into the result register.
// Reset: synchronous, active low; clears the parse state, the error, the step
// count, both valid flags, and sets the limit to all ones.
// Stall: while out_tready is low the result is held; an empty input register
// still takes one more transaction, then in_tready drops until the result is
// taken.
`default_nettype none

module variant_path_tokenizer #(
  parameter int INDEX_BITS = vpt_pkg::INDEX_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_tvalid,
  output      logic                      in_tready,
  input  wire logic [7:0]                in_tdata,   // [7:0] char_in
  input  wire logic                      in_tlast,   // req_type
  output      logic                      out_tvalid,
  input  wire logic                      out_tready,
  // [7:0] char_out, [9:8] char_role, [10] step_start, [18:11] step_count,
  // [49:19] index_value, [52:50] error_code, [55:53] zero
  output      logic [55:0]               out_tdata,
  output      logic                      out_tlast,  // path_done
  input  wire logic                      cfg_valid,
  output      logic                      cfg_ready,
  input  wire logic [vpt_pkg::CFG_W-1:0] cfg_data
);
  import vpt_pkg::*;

  localparam int ACC_W = acc_width(INDEX_BITS);

  logic             in_valid_r;
  item_t            item_r;
  logic             take;
  logic [ACC_W-1:0] lim;
  result_t          res;

  assign in_tready = !in_valid_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_valid_r <= 1'b1;
    end else if (take) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.req_type <= in_tlast;
      item_r.char_in  <= in_tdata;
    end
  end

  vpt_cfg #(
    .INDEX_BITS(INDEX_BITS)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .lim      (lim)
  );

  vpt_parse #(
    .INDEX_BITS(INDEX_BITS)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_valid(in_valid_r),
    .item      (item_r),
    .take      (take),
    .lim       (lim),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  assign out_tdata = {3'b000, res.error_code, res.index_value, res.step_count,
                      res.step_start, res.char_role, res.char_out};
  assign out_tlast = res.path_done;

endmodule

`default_nettype wire

### rtl/vpt_cfg.sv
// Index limit register of the variant path tokenizer, clamped to the
// accumulator width when written. Depends on vpt_pkg.
`default_nettype none

module vpt_cfg #(
  parameter int INDEX_BITS = vpt_pkg::INDEX_BITS_DEF
) (
  input  wire logic                                         clk,
  input  wire logic                                         rst_n,
  input  wire logic                                         cfg_valid,
  output      logic                                         cfg_ready,
  input  wire logic [vpt_pkg::CFG_W-1:0]                    cfg_data,
  output      logic [vpt_pkg::acc_width(INDEX_BITS)-1:0]    lim
);
  import vpt_pkg::*;

  localparam int ACC_W = acc_width(INDEX_BITS);

  logic [ACC_W-1:0] lim_r;
  logic [ACC_W-1:0] lim_nxt;

  generate
    if (ACC_W < CFG_W) begin : g_clamp
      assign lim_nxt = (|cfg_data[CFG_W-1:ACC_W]) ? {ACC_W{1'b1}} : cfg_data[ACC_W-1:0];
    end else begin : g_full
      assign lim_nxt = cfg_data[ACC_W-1:0];
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r <= {ACC_W{1'b1}};
    end else if (cfg_valid) begin
      lim_r <= lim_nxt;
    end
  end

  assign cfg_ready = 1'b1;
  assign lim       = lim_r;

endmodule

`default_nettype wire

### rtl/vpt_parse.sv
// Parse state machine and result register of the variant path tokenizer, using
// vpt_pkg; classifies a byte per cycle unless stalled, accumulates index digits.
`default_nettype none

module vpt_parse #(
  parameter int INDEX_BITS = vpt_pkg::INDEX_BITS_DEF
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst_n,
  input  wire logic                                      item_valid,
  input  wire vpt_pkg::item_t                            item,
  output      logic                                      take,
  input  wire logic [vpt_pkg::acc_width(INDEX_BITS)-1:0] lim,
  output      logic                                      res_valid,
  input  wire logic                                      res_ready,
  output      vpt_pkg::result_t                          res
);
  import vpt_pkg::*;

  localparam int ACC_W = acc_width(INDEX_BITS);

  typedef enum logic [2:0] {
    PH_START  = 3'd0,
    PH_FIRST  = 3'd1,
    PH_NAME   = 3'd2,
    PH_DOT    = 3'd3,
    PH_OPEN   = 3'd4,
    PH_DIGITS = 3'd5,
    PH_AFTER  = 3'd6
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic [2:0]        err_r, err_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [STEP_W-1:0] steps_r, steps_nxt;
  logic              res_valid_r;
  result_t           res_r, res_nxt;

  logic              fire;
  logic [CHAR_W-1:0] c;
  logic              is_digit;
  logic [ACC_W+3:0]  acc_ext;
  logic [ACC_W+3:0]  acc_mac;
  logic              over;

  assign take     = !res_valid_r || res_ready;
  assign fire     = item_valid && take;
  assign c        = item.char_in;
  assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
  assign acc_ext  = {4'b0000, acc_r};
  // acc * 10 + digit; the digit is the low nibble of an ASCII decimal
  assign acc_mac  = (acc_ext << 3) + (acc_ext << 1) + {{ACC_W{1'b0}}, c[3:0]};
  assign over     = acc_mac > {4'b0000, lim};

  always_comb begin
    logic name_grp;
    logic new_step;
    logic [1:0] role;
    logic start;
    name_grp  = 1'b0;
    new_step  = 1'b0;
    role      = ROLE_NONE;
    start     = 1'b0;
    phase_nxt = phase_r;
    err_nxt   = err_r;
    acc_nxt   = acc_r;
    steps_nxt = steps_r;

    if (item.req_type) begin
      if (err_r == ERR_OK) begin
        if (phase_r == PH_DOT) begin
          err_nxt = ERR_TRAIL_DOT;
        end else if (phase_r == PH_OPEN) begin
          err_nxt = ERR_NO_DIGITS;
        end else if (phase_r == PH_DIGITS) begin
          err_nxt = ERR_NO_CLOSE;
        end else if (steps_r == '0) begin
          err_nxt = ERR_EMPTY;
        end
      end
    end else if (err_r == ERR_OK) begin
      unique case (phase_r)
        PH_FIRST, PH_NAME, PH_AFTER: begin
          name_grp = 1'b1;
        end
        PH_DOT: begin
          if (c == CH_DOT || c == CH_OPEN) begin
            err_nxt = ERR_TRAIL_DOT;
          end else begin
            new_step  = 1'b1;
            role      = ROLE_NAME;
            phase_nxt = PH_NAME;
          end
        end
        PH_OPEN, PH_DIGITS: begin
          if (is_digit) begin
            if (over) begin
              acc_nxt = lim;
              err_nxt = ERR_RANGE;
            end else begin
              acc_nxt   = acc_mac[ACC_W-1:0];
              role      = ROLE_INDEX;
              phase_nxt = PH_DIGITS;
            end
          end else if (phase_r == PH_OPEN) begin
            err_nxt = ERR_NO_DIGITS;
          end else if (c == CH_CLOSE) begin
            role      = ROLE_INDEX;
            phase_nxt = PH_AFTER;
          end else begin
            err_nxt = ERR_NO_CLOSE;
          end
        end
        default: begin
          if (c == CH_DOLLAR) begin
            phase_nxt = PH_FIRST;
          end else begin
            name_grp = 1'b1;
          end
        end
      endcase

      if (name_grp) begin
        if (c == CH_DOT) begin
          phase_nxt = PH_DOT;
        end else if (c == CH_OPEN) begin
          new_step  = 1'b1;
          role      = ROLE_INDEX;
          phase_nxt = PH_OPEN;
        end else if (phase_r == PH_NAME) begin
          role = ROLE_NAME;
        end else if (phase_r == PH_AFTER) begin
          err_nxt = ERR_UNEXPECTED;
        end else begin
          new_step  = 1'b1;
          role      = ROLE_NAME;
          phase_nxt = PH_NAME;
        end
      end

      if (new_step) begin
        start   = 1'b1;
        acc_nxt = '0;
        if (steps_r != {STEP_W{1'b1}}) begin
          steps_nxt = steps_r + 1'b1;
        end
      end
    end

    res_nxt.char_out    = item.req_type ? '0 : c;
    res_nxt.char_role   = role;
    res_nxt.step_start  = start;
    res_nxt.step_count  = steps_nxt;
    res_nxt.index_value = IDX_OUT_W'(acc_nxt);
    res_nxt.error_code  = err_nxt;
    res_nxt.path_done   = item.req_type;

    // end of path clears the per-path state after reporting
    if (item.req_type) begin
      phase_nxt = PH_START;
      err_nxt   = ERR_OK;
      acc_nxt   = '0;
      steps_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_START;
      err_r       <= ERR_OK;
      acc_r       <= '0;
      steps_r     <= '0;
      res_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        phase_r <= phase_nxt;
        err_r   <= err_nxt;
        acc_r   <= acc_nxt;
        steps_r <= steps_nxt;
      end
      if (take) begin
        res_valid_r <= item_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res_nxt;
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

`default_nettype wire

### rtl/vpt_checker.sv
// Port-level checks for the variant path tokenizer, bound to the top level.
// Depends on vpt_pkg and variant_path_tokenizer.
`default_nettype none

module vpt_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [55:0] out_tdata,
  input wire logic        out_tlast
);
  import vpt_pkg::*;

  // end-of-path result carries no byte, no role and no step start
  a_end_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> (out_tdata[10:0] == 11'd0))
    else $error("end-of-path result carries byte data");

  // a byte only gets a role while no error is latched
  a_role_no_err: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[9:8] != ROLE_NONE)) |-> (out_tdata[52:50] == ERR_OK))
    else $error("byte role reported with error latched");

  // a step start is always a name or index byte, and the count is nonzero
  a_start_role: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[10]) |->
      ((out_tdata[9:8] != ROLE_NONE) && (out_tdata[18:11] != 8'd0)))
    else $error("step start without role or count");

  // empty path error only reported with zero steps on the end result
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[52:50] == ERR_EMPTY)) |->
      (out_tlast && (out_tdata[18:11] == 8'd0)))
    else $error("empty-path error with steps seen");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tlast)))
    else $error("stalled result changed");

endmodule

bind variant_path_tokenizer vpt_checker u_vpt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tlast (out_tlast)
);

`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for variant_path_tokenizer: drives path bytes and
// end-of-path transactions, predicts every result and compares field by field.
// Depends on vpt_pkg and the variant_path_tokenizer RTL.
`timescale 1ns / 1ps

module testbench;
  import vpt_pkg::*;

  typedef enum logic [2:0] {
    PH_START, PH_FIRST, PH_NAME, PH_DOT, PH_OPEN, PH_DIGITS, PH_AFTER
  } parse_ph_e;

  typedef struct packed {
    logic [7:0]  char_out;
    logic [1:0]  role;
    logic        start;
    logic [7:0]  count;
    logic [30:0] idx;
    logic [2:0]  err;
    logic        done;
  } token_t;

  typedef struct packed {
    logic       last;
    logic [7:0] ch;
    logic       typed;
    token_t     want;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;
  logic        out_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [30:0] cfg_data;

  // predictor state
  parse_ph_e   ph_st;
  logic [2:0]  err_st;
  logic [30:0] accum_st;
  logic [7:0]  steps_st;
  logic [30:0] cur_limit;

  token_t expected_tokens[$];
  int     mismatches;
  bit     steady;
  bit     hold_req;

  localparam int DIR_ROWS = 25;
  stim_row_t dir_rows [DIR_ROWS] = '{
    '{1'b1, 8'h00,     1'b1, '{8'h00, ROLE_NONE, 1'b0, 8'd0, 31'd0, ERR_EMPTY, 1'b1}},
    '{1'b0, CH_DOLLAR, 1'b1, '{CH_DOLLAR, ROLE_NONE, 1'b0, 8'd0, 31'd0, ERR_OK, 1'b0}},
    '{1'b1, 8'hFF,     1'b1, '{8'h00, ROLE_NONE, 1'b0, 8'd0, 31'd0, ERR_EMPTY, 1'b1}},
    '{1'b0, CH_DOT,    1'b0, '0},
    '{1'b1, 8'h00,     1'b1, '{8'h00, ROLE_NONE, 1'b0, 8'd0, 31'd0, ERR_TRAIL_DOT, 1'b1}},
    '{1'b0, 8'h00,     1'b0, '0},
    '{1'b0, CH_OPEN,   1'b0, '0},
    '{1'b0, CH_NINE,   1'b0, '0},
    '{1'b0, CH_CLOSE,  1'b0, '0},
    '{1'b0, "x",       1'b0, '0},
    '{1'b1, 8'h00,     1'b0, '0},
    '{1'b0, CH_OPEN,   1'b0, '0},
    '{1'b1, 8'h00,     1'b1, '{8'h00, ROLE_NONE, 1'b0, 8'd1, 31'd0, ERR_NO_DIGITS, 1'b1}},
    '{1'b0, CH_CLOSE,  1'b0, '0},
    '{1'b0, CH_DOLLAR, 1'b0, '0},
    '{1'b0, CH_OPEN,   1'b0, '0},
    '{1'b0, "4",       1'b0, '0},
    '{1'b0, "z",       1'b0, '0},
    '{1'b1, 8'h00,     1'b0, '0},
    '{1'b0, 8'hFF,     1'b0, '0},
    '{1'b0, CH_OPEN,   1'b0, '0},
    '{1'b0, "1",       1'b0, '0},
    '{1'b0, CH_ZERO,   1'b0, '0},
    '{1'b0, "1",       1'b0, '0},
    '{1'b1, 8'h00,     1'b0, '0}
  };

  variant_path_tokenizer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAIL variant_path_tokenizer");
    $finish;
  end

  function automatic void open_step();
    if (steps_st != 8'd255) steps_st++;
    accum_st = '0;
  endfunction

  function automatic token_t tokenize_byte(logic last, logic [7:0] ch);
    token_t t;
    parse_ph_e ph;
    longint unsigned d;
    longint unsigned lim;
    t = '0;
    lim = cur_limit;
    if (last) begin
      t.done = 1'b1;
      if (err_st == ERR_OK) begin
        if (ph_st == PH_DOT) err_st = ERR_TRAIL_DOT;
        else if (ph_st == PH_OPEN) err_st = ERR_NO_DIGITS;
        else if (ph_st == PH_DIGITS) err_st = ERR_NO_CLOSE;
        else if (steps_st == 8'd0) err_st = ERR_EMPTY;
      end
    end else begin
      t.char_out = ch;
      if (err_st == ERR_OK) begin
        ph = ph_st;
        if (ph == PH_START && ch == CH_DOLLAR) begin
          ph_st = PH_FIRST;
        end else if (ph == PH_START || ph == PH_FIRST || ph == PH_NAME || ph == PH_AFTER) begin
          if (ch == CH_DOT) begin
            ph_st = PH_DOT;
          end else if (ch == CH_OPEN) begin
            open_step();
            t.role = ROLE_INDEX;
            t.start = 1'b1;
            ph_st = PH_OPEN;
          end else if (ph == PH_NAME) begin
            t.role = ROLE_NAME;
          end else if (ph == PH_AFTER) begin
            err_st = ERR_UNEXPECTED;
          end else begin
            open_step();
            t.role = ROLE_NAME;
            t.start = 1'b1;
            ph_st = PH_NAME;
          end
        end else if (ph == PH_DOT) begin
          if (ch == CH_DOT || ch == CH_OPEN) begin
            err_st = ERR_TRAIL_DOT;
          end else begin
            open_step();
            t.role = ROLE_NAME;
            t.start = 1'b1;
            ph_st = PH_NAME;
          end
        end else if (ch >= CH_ZERO && ch <= CH_NINE) begin
          d = longint'(ch - CH_ZERO);
          if (d > lim || longint'(accum_st) > (lim - d) / 10) begin
            accum_st = cur_limit;
            err_st = ERR_RANGE;
          end else begin
            accum_st = 31'(longint'(accum_st) * 10 + d);
            t.role = ROLE_INDEX;
            ph_st = PH_DIGITS;
          end
        end else if (ph == PH_OPEN) begin
          err_st = ERR_NO_DIGITS;
        end else if (ch == CH_CLOSE) begin
          t.role = ROLE_INDEX;
          ph_st = PH_AFTER;
        end else begin
          err_st = ERR_NO_CLOSE;
        end
      end
    end
    t.count = steps_st;
    t.idx = accum_st;
    t.err = err_st;
    if (t.done) begin
      ph_st = PH_START;
      err_st = ERR_OK;
      accum_st = '0;
      steps_st = '0;
    end
    return t;
  endfunction

  task automatic flag_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  always @(posedge clk) begin
    token_t got;
    token_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tdata[7:0], out_tdata[9:8], out_tdata[10], out_tdata[18:11],
              out_tdata[49:19], out_tdata[52:50], out_tlast};
      if (expected_tokens.size() == 0) begin
        flag_mismatch("result with nothing pending", 0, 0);
      end else begin
        want = expected_tokens.pop_front();
        if (got.char_out != want.char_out) flag_mismatch("char_out", got.char_out, want.char_out);
        if (got.role != want.role) flag_mismatch("char_role", got.role, want.role);
        if (got.start != want.start) flag_mismatch("step_start", got.start, want.start);
        if (got.count != want.count) flag_mismatch("step_count", got.count, want.count);
        if (got.idx != want.idx) flag_mismatch("index_value", got.idx, want.idx);
        if (got.err != want.err) flag_mismatch("error_code", got.err, want.err);
        if (got.done != want.done) flag_mismatch("path_done", got.done, want.done);
      end
    end
  end

  // result side: random back-pressure, a long hold-off on request
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (80) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_tready <= steady || ($urandom_range(0, 99) >= 25);
      end
    end
  end

  task automatic send_item(logic last, logic [7:0] ch, logic typed, token_t want);
    token_t t;
    while (!steady && $urandom_range(0, 99) < 25) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ch;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    t = tokenize_byte(last, ch);
    expected_tokens.insert(expected_tokens.size(), typed ? want : t);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(logic [30:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cur_limit = v;
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] name_byte();
    logic [7:0] c;
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 2))
        0: c = CH_DOLLAR;
        1: c = CH_CLOSE;
        default: c = CH_ZERO + 8'($urandom_range(0, 9));
      endcase
    end else begin
      do c = 8'($urandom_range(0, 255)); while (c == CH_DOT || c == CH_OPEN);
    end
    return c;
  endfunction

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 7))
      0: return CH_DOLLAR;
      1: return CH_DOT;
      2: return CH_OPEN;
      3: return CH_CLOSE;
      4: return CH_ZERO;
      5: return CH_NINE;
      6: return "a";
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void add_index(ref logic [7:0] p[$]);
    longint unsigned v;
    logic [7:0] digs[$];
    int zeros;
    case ($urandom_range(0, 5))
      0: v = cur_limit;
      1: v = longint'(cur_limit) + 1;
      2: v = (cur_limit == 0) ? 0 : longint'(cur_limit) - 1;
      3: v = $urandom_range(0, cur_limit);
      4: v = $urandom_range(0, 99);
      default: v = longint'($urandom) * 5 + $urandom_range(0, 9);
    endcase
    zeros = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 2) : 0;
    repeat (zeros) p.insert(p.size(), CH_ZERO);
    do begin
      digs.push_front(CH_ZERO + 8'(v % 10));
      v = v / 10;
    end while (v != 0);
    foreach (digs[k]) p.insert(p.size(), digs[k]);
  endfunction

  function automatic void build_path(ref logic [7:0] p[$]);
    int n;
    int k;
    p.delete();
    if ($urandom_range(0, 3) == 0) p.insert(p.size(), CH_DOLLAR);
    n = $urandom_range(1, 4);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 1)) begin
        if (i > 0 || $urandom_range(0, 3) == 0) p.insert(p.size(), CH_DOT);
        repeat ($urandom_range(1, 4)) p.insert(p.size(), name_byte());
      end else begin
        p.insert(p.size(), CH_OPEN);
        add_index(p);
        p.insert(p.size(), CH_CLOSE);
      end
    end
    if ($urandom_range(0, 99) < 35) begin
      case ($urandom_range(0, 4))
        0: p.insert($urandom_range(0, p.size()), noise_byte());
        1: if (p.size() > 0) p.delete($urandom_range(0, p.size() - 1));
        2: begin
          k = $urandom_range(0, p.size());
          while (p.size() > k) p.delete(p.size() - 1);
        end
        3: p.insert(p.size(), CH_DOT);
        default: begin
          p.delete();
          repeat ($urandom_range(0, 6)) p.insert(p.size(), noise_byte());
        end
      endcase
    end
  endfunction

  initial begin
    logic [30:0] limits [8];
    logic [7:0]  path_q[$];
    int          sent;
    bit          paused;

    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tlast   <= 1'b0;
    cfg_valid  <= 1'b0;
    cfg_data   <= '0;
    steady     = 1'b0;
    hold_req   = 1'b0;
    mismatches = 0;
    ph_st      = PH_START;
    err_st     = ERR_OK;
    accum_st   = '0;
    steps_st   = '0;
    cur_limit  = 31'h7FFF_FFFF;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_limit(31'd100);
    foreach (dir_rows[i])
      send_item(dir_rows[i].last, dir_rows[i].ch, dir_rows[i].typed, dir_rows[i].want);

    limits = '{31'd0, 31'd9, 31'd10, 31'h7FFF_FFFF, 31'd1,
               31'($urandom_range(11, 99999)), 31'h7FFF_FFFE,
               31'($urandom_range(0, 32'h7FFF_FFFF))};
    paused = 1'b0;
    for (int ph = 0; ph < 8; ph++) begin
      wait_drained();
      write_limit(limits[ph]);
      steady = (ph == 4);
      if (ph == 1) hold_req = 1'b1;
      if (ph == 3) begin
        // step count saturation
        send_item(1'b0, "a", 1'b0, '0);
        repeat (300) begin
          send_item(1'b0, CH_DOT, 1'b0, '0);
          send_item(1'b0, "b", 1'b0, '0);
        end
        send_item(1'b1, 8'h00, 1'b0, '0);
      end
      sent = 0;
      while (sent < 150) begin
        if (ph == 2 && sent >= 80 && !paused) begin
          wait_drained();
          paused = 1'b1;
        end
        build_path(path_q);
        foreach (path_q[k]) send_item(1'b0, path_q[k], 1'b0, '0);
        send_item(1'b1, 8'($urandom_range(0, 255)), 1'b0, '0);
        sent += path_q.size() + 1;
      end
    end
    steady = 1'b0;

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_tokens.size() == 0) begin
      $display("PASS variant_path_tokenizer");
    end else begin
      $display("FAIL variant_path_tokenizer");
    end
    $finish;
  end

endmodule
